>>> rtl/core/cia_pkg.sv
// Package: shared types and constants for the interface adapter.
package cia_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_PEEK  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    REG_PRA  = 4'd0,
    REG_PRB  = 4'd1,
    REG_DDRA = 4'd2,
    REG_DDRB = 4'd3,
    REG_TALO = 4'd4,
    REG_TAHI = 4'd5,
    REG_TBLO = 4'd6,
    REG_TBHI = 4'd7,
    REG_TOD0 = 4'd8,
    REG_TODS = 4'd9,
    REG_TODM = 4'd10,
    REG_TODH = 4'd11,
    REG_SDR  = 4'd12,
    REG_ICR  = 4'd13,
    REG_CRA  = 4'd14,
    REG_CRB  = 4'd15
  } reg_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] address;
    logic [7:0] write_data;
  } cia_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic [7:0] port_a_value;
    logic [7:0] port_b_value;
  } cia_out_t;

  localparam logic [15:0] TIMER_RESET = 16'hFFFF;
  localparam logic [19:0] PERIOD_RESET = 20'd98524;

  // 7-bit BCD (two digits) increment with wrap at 60, result truncated.
  function automatic logic [7:0] bcd_inc60(input logic [6:0] v, output logic carry);
    logic [7:0] b;
    logic [3:0] hi, lo;
    b = {4'd0, 1'b0, v[6:4]} * 8'd10 + {4'd0, v[3:0]} + 8'd1;
    carry = (b == 8'd60);
    if (carry) b = 8'd0;
    hi = 4'((16'(b) * 16'd205) >> 11);
    lo = 4'(b - 8'(hi) * 8'd10);
    return {1'b0, 3'(hi), lo};
  endfunction

  function automatic logic [25:0] tod_inc(input logic [25:0] t);
    logic [3:0] tth;
    logic [6:0] sec, mn;
    logic [7:0] hr, bh, b;
    logic [7:0] r;
    logic       cs, cm, pm;
    logic [3:0] hi, lo;
    tth = t[3:0] + 4'd1;
    sec = t[10:4];
    mn = t[17:11];
    hr = t[25:18];
    if (tth == 4'd10) begin
      tth = 4'd0;
      r = bcd_inc60(sec, cs);
      if (cs) begin
        r = bcd_inc60(mn, cm);
        if (cm) begin
          pm = hr[7];
          bh = {3'd0, 1'b0, hr[4]} * 8'd10 + {4'd0, hr[3:0]} + (pm ? 8'd12 : 8'd0)
               + 8'd1;
          if (bh == 8'd24) begin
            bh = 8'd0;
            pm = 1'b0;
          end else if (bh == 8'd12) begin
            pm = 1'b1;
          end
          b = bh - (pm ? 8'd12 : 8'd0);
          hi = 4'((16'(b) * 16'd205) >> 11);
          lo = 4'(b - 8'(hi) * 8'd10);
          hr = {pm, 2'b00, hi[0], lo};
        end
        mn = r[6:0];
        r = 8'd0;
      end
      sec = (cs) ? 7'd0 : r[6:0];
    end
    return {hr, mn, sec, tth};
  endfunction

endpackage

>>> rtl/core/cia_core.sv
// Core state and per-item update logic for the interface adapter.
module cia_core
  import cia_pkg::*;
#(
  parameter int COUNTDOWN_WIDTH = 20
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  cia_in_t  item,
  input  logic [19:0] period,
  output cia_out_t result
);

  logic [15:0] ta_cnt, ta_lat, tb_cnt, tb_lat;
  logic [7:0]  cra, crb, pra, prb, ddra, ddrb, flags;
  logic [4:0]  mask;
  logic [25:0] clk_t, alm_t, lat_t;
  logic        running;
  logic [COUNTDOWN_WIDTH-1:0] cdown;

  logic [15:0] ta_cnt_next, ta_lat_next, tb_cnt_next, tb_lat_next;
  logic [7:0]  cra_next, crb_next, pra_next, prb_next, ddra_next, ddrb_next, flags_next;
  logic [4:0]  mask_next;
  logic [25:0] clk_t_next, alm_t_next, lat_t_next, tinc;
  logic        running_next, a_under, b_under, b_counts;
  logic [COUNTDOWN_WIDTH-1:0] cdown_next;
  logic [7:0]  rd;
  logic [15:0] ta_dec, tb_dec;
  logic [25:0] todw;
  logic [25:0] todm;
  op_t         op;
  reg_t        ad;
  logic [7:0]  d;

  assign op = op_t'(item.operation);
  assign ad = reg_t'(item.address);
  assign d = item.write_data;
  assign ta_dec = ta_cnt - 16'd1;
  assign tb_dec = tb_cnt - 16'd1;
  assign tinc = tod_inc(clk_t);

  always_comb begin
    ta_cnt_next = ta_cnt; ta_lat_next = ta_lat; tb_cnt_next = tb_cnt; tb_lat_next = tb_lat;
    cra_next = cra; crb_next = crb; pra_next = pra; prb_next = prb;
    ddra_next = ddra; ddrb_next = ddrb; flags_next = flags; mask_next = mask;
    clk_t_next = clk_t; alm_t_next = alm_t; lat_t_next = lat_t;
    running_next = running; cdown_next = cdown;
    rd = 8'd0; a_under = 1'b0; b_under = 1'b0; b_counts = 1'b0;
    todw = 26'd0; todm = 26'd0;
    unique case (op)
      OP_TICK: begin
        if (cra[0]) begin
          if (cra[1] && !cra[2]) prb_next[6] = 1'b0;
          if (!cra[5]) begin
            ta_cnt_next = ta_dec;
            if (ta_dec == TIMER_RESET) begin
              a_under = 1'b1;
              ta_cnt_next = ta_lat;
              if (cra[1]) prb_next[6] = cra[2] ? ~prb_next[6] : 1'b1;
              if (cra[3]) cra_next[0] = 1'b0;
            end
          end
        end
        b_counts = (crb[6:5] == 2'd0) || (crb[6:5] == 2'd2 && a_under);
        if (crb[0]) begin
          if (crb[1] && !crb[2]) prb_next[7] = 1'b0;
          if (b_counts) begin
            tb_cnt_next = tb_dec;
            if (tb_dec == TIMER_RESET) begin
              b_under = 1'b1;
              tb_cnt_next = tb_lat;
              if (crb[1]) prb_next[7] = crb[2] ? ~prb_next[7] : 1'b1;
              if (crb[3]) crb_next[0] = 1'b0;
            end
          end
        end
        if (a_under) flags_next[0] = 1'b1;
        if (b_under) flags_next[1] = 1'b1;
        if (running) begin
          if (cdown == '0) begin
            clk_t_next = tinc;
            cdown_next = COUNTDOWN_WIDTH'(period);
            if (tinc == alm_t) flags_next[2] = 1'b1;
          end else begin
            cdown_next = cdown - 1'b1;
          end
        end
        if (|(flags_next[4:0] & mask)) flags_next[7] = 1'b1;
      end
      OP_READ, OP_PEEK: begin
        unique case (ad)
          REG_PRA:  rd = pra;
          REG_PRB:  rd = prb;
          REG_DDRA: rd = ddra;
          REG_DDRB: rd = ddrb;
          REG_TALO: rd = ta_cnt[7:0];
          REG_TAHI: rd = ta_cnt[15:8];
          REG_TBLO: rd = tb_cnt[7:0];
          REG_TBHI: rd = tb_cnt[15:8];
          REG_TOD0: rd = {4'd0, lat_t[3:0]};
          REG_TODS: rd = {1'b0, lat_t[10:4]};
          REG_TODM: rd = {1'b0, lat_t[17:11]};
          REG_TODH: begin
            rd = clk_t[25:18];
            if (op == OP_READ) lat_t_next = clk_t;
          end
          REG_ICR: begin
            rd = flags;
            if (op == OP_READ) flags_next = 8'd0;
          end
          REG_CRA:  rd = cra;
          REG_CRB:  rd = crb;
          REG_SDR:  rd = 8'd0;
          default:  rd = 8'd0;
        endcase
      end
      OP_WRITE: begin
        unique case (ad)
          REG_TOD0: begin todw = {22'd0, d[3:0]};        todm = 26'hF; end
          REG_TODS: begin todw = {15'd0, d[6:0], 4'd0};  todm = 26'h7F << 4; end
          REG_TODM: begin todw = {8'd0, d[6:0], 11'd0};  todm = 26'h7F << 11; end
          REG_TODH: begin todw = {d & 8'h9F, 18'd0};     todm = 26'hFF << 18; end
          default: begin todw = 26'd0; todm = 26'd0; end
        endcase
        if (crb[7]) alm_t_next = (alm_t & ~todm) | todw;
        else        clk_t_next = (clk_t & ~todm) | todw;
        unique case (ad)
          REG_PRA:  pra_next = (pra & ~ddra) | (d & ddra);
          REG_PRB:  prb_next = (prb & ~ddrb) | (d & ddrb);
          REG_DDRA: ddra_next = d;
          REG_DDRB: ddrb_next = d;
          REG_TALO: ta_lat_next = {ta_lat[15:8], d};
          REG_TAHI: begin
            ta_lat_next = {d, ta_lat[7:0]};
            if (!cra[0]) ta_cnt_next = {d, ta_lat[7:0]};
          end
          REG_TBLO: tb_lat_next = {tb_lat[15:8], d};
          REG_TBHI: begin
            tb_lat_next = {d, tb_lat[7:0]};
            if (!crb[0]) tb_cnt_next = {d, tb_lat[7:0]};
          end
          REG_TOD0: if (!crb[7]) running_next = 1'b1;
          REG_TODH: if (!crb[7]) running_next = 1'b0;
          REG_ICR:  mask_next = d[7] ? (mask | d[4:0]) : (mask & ~d[4:0]);
          REG_CRA: begin
            if (d[4]) ta_cnt_next = ta_lat;
            if (!cra[0] && d[2:0] == 3'b111) prb_next[6] = 1'b1;
            cra_next = d & 8'hEF;
          end
          REG_CRB: begin
            if (d[4]) tb_cnt_next = tb_lat;
            if (!crb[0] && d[2:0] == 3'b111) prb_next[7] = 1'b1;
            crb_next = d & 8'hEF;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ta_cnt <= TIMER_RESET; ta_lat <= TIMER_RESET;
      tb_cnt <= TIMER_RESET; tb_lat <= TIMER_RESET;
      cra <= '0; crb <= '0; pra <= '0; prb <= '0; ddra <= '0; ddrb <= '0;
      flags <= '0; mask <= '0; clk_t <= '0; alm_t <= '0; lat_t <= '0;
      running <= 1'b0; cdown <= '0;
    end else if (en) begin
      ta_cnt <= ta_cnt_next; ta_lat <= ta_lat_next;
      tb_cnt <= tb_cnt_next; tb_lat <= tb_lat_next;
      cra <= cra_next; crb <= crb_next; pra <= pra_next; prb <= prb_next;
      ddra <= ddra_next; ddrb <= ddrb_next; flags <= flags_next; mask <= mask_next;
      clk_t <= clk_t_next; alm_t <= alm_t_next; lat_t <= lat_t_next;
      running <= running_next; cdown <= cdown_next;
    end
  end

  always_comb begin
    result.read_data = rd;
    result.irq = flags_next[7];
    result.port_a_value = pra_next;
    result.port_b_value = prb_next;
  end

endmodule

>>> rtl/core/complex_interface_adapter_unit.sv
// Top level: handshake and output register around the adapter core.
// One item (tick, read, write or peek) is accepted per cycle; its result
// appears in the output register the cycle after acceptance. The output
// register holds one result, so input stalls only while that result waits.
module complex_interface_adapter_unit
  import cia_pkg::*;
#(
  parameter int COUNTDOWN_WIDTH = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  cia_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output cia_out_t    out_data,
  input  logic        cfg_we,
  input  logic [19:0] cfg_data
);

  logic [19:0] period;
  logic        take;
  cia_out_t    res;

  assign in_ready = !out_valid || out_ready;
  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) period <= PERIOD_RESET;
    else if (cfg_we) period <= cfg_data;
  end

  cia_core #(.COUNTDOWN_WIDTH(COUNTDOWN_WIDTH)) u_core (
    .clk(clk), .rst(rst), .en(take), .item(in_data), .period(period), .result(res)
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (in_ready) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (take) out_data <= res;
  end

endmodule

>>> tb/tb_top.sv
// Testbench for complex_interface_adapter_unit: self-checking, with directed and random transfers.
module tb_top;
  import cia_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  cia_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  cia_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [19:0] cfg_data = '0;

  complex_interface_adapter_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // predicted adapter state
  logic [15:0] ta_cnt, ta_lat, tb_cnt, tb_lat;
  logic [7:0]  ta_ctl, tb_ctl;
  logic [25:0] tod_now, tod_alarm, tod_held;
  logic        tod_run;
  logic [19:0] tenth_cnt, tenth_period;
  logic [7:0]  pa, pb, pa_dir, pb_dir, icr_flags;
  logic [4:0]  icr_mask;

  cia_out_t expected_q[$];
  int mismatches = 0;
  int send_idle = 0, recv_idle = 0;
  int hold_reqs = 0, hold_seen = 0, hold_left = 0;
  int quiet_cycles = 0;

  function automatic int unbcd(input logic [7:0] v);
    return v[7:4] * 10 + v[3:0];
  endfunction

  function automatic logic [7:0] tobcd(input int v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic logic [25:0] tod_next(input logic [25:0] t);
    logic [3:0] tth;
    logic [6:0] sec, mins;
    logic [7:0] hr;
    int bs, bm, bh, pm;
    tth = t[3:0] + 4'd1;
    sec = t[10:4];
    mins = t[17:11];
    hr = t[25:18];
    if (tth == 4'd10) begin
      tth = 4'd0;
      bs = unbcd({1'b0, sec}) + 1;
      if (bs == 60) begin
        bs = 0;
        bm = unbcd({1'b0, mins}) + 1;
        if (bm == 60) begin
          bm = 0;
          pm = hr[7] ? 12 : 0;
          bh = unbcd({3'b0, hr[4:0]}) + pm + 1;
          if (bh == 24) begin
            bh = 0;
            pm = 0;
          end else if (bh == 12) begin
            pm = 12;
          end
          hr = {pm != 0, 2'b00, 5'(tobcd(bh - pm))};
        end
        mins = 7'(tobcd(bm));
      end
      sec = 7'(tobcd(bs));
    end
    return {hr, mins, sec, tth};
  endfunction

  task automatic model_reset();
    ta_cnt = TIMER_RESET; ta_lat = TIMER_RESET; ta_ctl = '0;
    tb_cnt = TIMER_RESET; tb_lat = TIMER_RESET; tb_ctl = '0;
    tod_now = '0; tod_alarm = '0; tod_held = '0; tod_run = 1'b0;
    tenth_cnt = '0; tenth_period = PERIOD_RESET;
    pa = '0; pb = '0; pa_dir = '0; pb_dir = '0; icr_flags = '0; icr_mask = '0;
  endtask

  task automatic timer_tick(input bit is_b, input bit counts, output bit under);
    logic [15:0] cnt, lat;
    logic [7:0] ctl, pbit;
    cnt = is_b ? tb_cnt : ta_cnt;
    lat = is_b ? tb_lat : ta_lat;
    ctl = is_b ? tb_ctl : ta_ctl;
    pbit = is_b ? 8'h80 : 8'h40;
    under = 1'b0;
    if (ctl[0]) begin
      if (ctl[1] && !ctl[2]) pb = pb & ~pbit;
      if (counts) begin
        cnt = cnt - 16'd1;
        if (cnt == 16'hFFFF) begin
          under = 1'b1;
          cnt = lat;
          if (ctl[1]) pb = ctl[2] ? (pb ^ pbit) : (pb | pbit);
          if (ctl[3]) ctl[0] = 1'b0;
        end
      end
    end
    if (is_b) begin
      tb_cnt = cnt; tb_ctl = ctl;
    end else begin
      ta_cnt = cnt; ta_ctl = ctl;
    end
  endtask

  task automatic control_write(input bit is_b, input logic [7:0] d);
    logic [7:0] pbit;
    pbit = is_b ? 8'h80 : 8'h40;
    if (d[4]) begin
      if (is_b) tb_cnt = tb_lat; else ta_cnt = ta_lat;
      d[4] = 1'b0;
    end
    if (!(is_b ? tb_ctl[0] : ta_ctl[0]) && d[2:0] == 3'b111) pb = pb | pbit;
    if (is_b) tb_ctl = d; else ta_ctl = d;
  endtask

  task automatic model_step(input cia_in_t it, output cia_out_t r);
    logic [7:0] rd, d;
    logic [25:0] t;
    bit a_under, b_under, alarm;
    rd = '0;
    d = it.write_data;
    case (it.operation)
      OP_TICK: begin
        timer_tick(1'b0, !ta_ctl[5], a_under);
        if (a_under) icr_flags[0] = 1'b1;
        timer_tick(1'b1, tb_ctl[6:5] == 2'd0 || (tb_ctl[6:5] == 2'd2 && a_under), b_under);
        if (b_under) icr_flags[1] = 1'b1;
        if (tod_run) begin
          if (tenth_cnt == '0) begin
            tod_now = tod_next(tod_now);
            tenth_cnt = tenth_period;
            if (tod_now == tod_alarm) icr_flags[2] = 1'b1;
          end else begin
            tenth_cnt = tenth_cnt - 20'd1;
          end
        end
        if (!icr_flags[7] && (icr_flags[4:0] & icr_mask) != '0) icr_flags[7] = 1'b1;
      end
      OP_READ, OP_PEEK: begin
        case (reg_t'(it.address))
          REG_PRA:  rd = pa;
          REG_PRB:  rd = pb;
          REG_DDRA: rd = pa_dir;
          REG_DDRB: rd = pb_dir;
          REG_TALO: rd = ta_cnt[7:0];
          REG_TAHI: rd = ta_cnt[15:8];
          REG_TBLO: rd = tb_cnt[7:0];
          REG_TBHI: rd = tb_cnt[15:8];
          REG_TOD0: rd = {4'd0, tod_held[3:0]};
          REG_TODS: rd = {1'b0, tod_held[10:4]};
          REG_TODM: rd = {1'b0, tod_held[17:11]};
          REG_TODH: begin
            if (it.operation == OP_READ) tod_held = tod_now;
            rd = tod_now[25:18];
          end
          REG_ICR: begin
            rd = icr_flags;
            if (it.operation == OP_READ) icr_flags = '0;
          end
          REG_CRA: rd = ta_ctl;
          REG_CRB: rd = tb_ctl;
          default: rd = '0;
        endcase
      end
      default: begin
        alarm = tb_ctl[7];
        t = alarm ? tod_alarm : tod_now;
        case (reg_t'(it.address))
          REG_PRA:  pa = (pa & ~pa_dir) | (d & pa_dir);
          REG_PRB:  pb = (pb & ~pb_dir) | (d & pb_dir);
          REG_DDRA: pa_dir = d;
          REG_DDRB: pb_dir = d;
          REG_TALO: ta_lat[7:0] = d;
          REG_TAHI: begin
            ta_lat[15:8] = d;
            if (!ta_ctl[0]) ta_cnt = ta_lat;
          end
          REG_TBLO: tb_lat[7:0] = d;
          REG_TBHI: begin
            tb_lat[15:8] = d;
            if (!tb_ctl[0]) tb_cnt = tb_lat;
          end
          REG_TOD0: begin
            t[3:0] = d[3:0];
            if (!alarm) tod_run = 1'b1;
          end
          REG_TODS: t[10:4] = d[6:0];
          REG_TODM: t[17:11] = d[6:0];
          REG_TODH: begin
            t[25:18] = d & 8'h9F;
            if (!alarm) tod_run = 1'b0;
          end
          REG_ICR: begin
            if (d[7]) icr_mask = icr_mask | d[4:0];
            else icr_mask = icr_mask & ~d[4:0];
          end
          REG_CRA: control_write(1'b0, d);
          REG_CRB: control_write(1'b1, d);
          default: ;
        endcase
        if (alarm) tod_alarm = t; else tod_now = t;
      end
    endcase
    r.read_data = rd;
    r.irq = icr_flags[7];
    r.port_a_value = pa;
    r.port_b_value = pb;
  endtask

  // receiver: random stalls plus requested long hold-offs
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin : check_results
    cia_out_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer: %p", out_data);
        end else begin
          want = expected_q.pop_front();
          if (out_data.read_data !== want.read_data || out_data.irq !== want.irq ||
              out_data.port_a_value !== want.port_a_value ||
              out_data.port_b_value !== want.port_b_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: rd %h/%h irq %b/%b pa %h/%h pb %h/%h (exp/got)",
                       want.read_data, out_data.read_data, want.irq, out_data.irq,
                       want.port_a_value, out_data.port_a_value,
                       want.port_b_value, out_data.port_b_value);
          end
        end
      end
      if (in_valid && in_ready) begin
        model_step(in_data, want);
        expected_q.push_back(want);
      end
      if (cfg_we) tenth_period = cfg_data;
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [3:0] addr,
                           input logic [7:0] d);
    cia_in_t it;
    it.operation = op;
    it.address = addr;
    it.write_data = d;
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_period(input logic [19:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic tick(input int n);
    repeat (n) send_item(OP_TICK, REG_PRA, 8'($urandom));
  endtask

  task automatic test_directed();
    send_item(OP_WRITE, REG_DDRA, 8'hFF);
    send_item(OP_WRITE, REG_PRA, 8'hFF);
    send_item(OP_WRITE, REG_DDRB, 8'h0F);
    send_item(OP_WRITE, REG_PRB, 8'hFF);
    send_item(OP_WRITE, REG_SDR, 8'hAA);
    send_item(OP_READ, REG_SDR, 8'h00);
    send_item(OP_WRITE, REG_TODH, 8'hFF);
    send_item(OP_WRITE, REG_TODM, 8'h59);
    send_item(OP_WRITE, REG_TODS, 8'h59);
    send_item(OP_WRITE, REG_TOD0, 8'h09);
    send_item(OP_WRITE, REG_ICR, 8'h87);
    send_item(OP_WRITE, REG_TALO, 8'h02);
    send_item(OP_WRITE, REG_TAHI, 8'h00);
    send_item(OP_WRITE, REG_CRA, 8'h07);
    send_item(OP_WRITE, REG_TBLO, 8'h01);
    send_item(OP_WRITE, REG_TBHI, 8'h00);
    send_item(OP_WRITE, REG_CRB, 8'h4B);
    tick(8);
    send_item(OP_PEEK, REG_ICR, 8'h00);
    send_item(OP_PEEK, REG_TODH, 8'h00);
    send_item(OP_READ, REG_TODH, 8'h00);
    send_item(OP_READ, REG_TOD0, 8'h00);
    send_item(OP_READ, REG_ICR, 8'h00);
    send_item(OP_WRITE, REG_CRB, 8'h90);
    send_item(OP_WRITE, REG_TOD0, 8'h05);
    send_item(OP_WRITE, REG_ICR, 8'h1F);
    send_item(OP_WRITE, REG_CRA, 8'h39);
    tick(4);
  endtask

  task automatic random_item();
    logic [3:0] addr;
    int r;
    r = $urandom_range(99);
    if (r < 45) begin
      send_item(OP_TICK, 4'($urandom), 8'($urandom));
    end else if (r < 65) begin
      addr = 4'($urandom_range(REG_TALO, REG_TBHI));
      send_item(OP_WRITE, addr, addr[0] ? 8'($urandom_range(0, 1)) : 8'($urandom_range(0, 15)));
    end else if (r < 75) begin
      send_item(OP_WRITE, $urandom_range(1) ? REG_CRA : REG_CRB, 8'($urandom));
    end else if (r < 82) begin
      send_item(OP_WRITE, REG_ICR, 8'($urandom) | 8'h80);
    end else begin
      send_item(2'($urandom), 4'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_random(input int n, input int s_idle, input int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    repeat (n) random_item();
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    hold_reqs++;
    repeat (150) random_item();
  endtask

  initial begin
    model_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_period(20'd1);
    test_directed();
    set_period(20'd3);
    test_random(200, 20, 60);
    set_period(20'hFFFFF);
    test_random(200, 60, 20);
    set_period(20'($urandom_range(1, 5)));
    test_random(100, 0, 0);
    test_backpressure();
    drain();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/cia_pkg.sv
rtl/core/cia_core.sv
rtl/core/complex_interface_adapter_unit.sv
tb/tb_top.sv
